FILE: design/rtwfc_pkg.sv
// Package for the region table with fault check.
// Holds request and status codes, the queued request type and permission flag constants.
package rtwfc_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_FAULT  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_OVERLAP   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NO_REGION = 3'd4,
    ST_NO_WRITE  = 3'd5,
    ST_READ_PRES = 3'd6,
    ST_NO_READ   = 3'd7
  } status_e;

  localparam logic [2:0] FLAG_READ      = 3'h1;
  localparam logic [2:0] FLAG_WRITE     = 3'h2;
  localparam logic [2:0] FLAG_EXEC      = 3'h4;
  localparam logic [2:0] ENTRY_USER     = 3'h4;
  localparam logic [2:0] ENTRY_WRITABLE = 3'h2;

  // One classified request as it waits between front and back
  typedef struct packed {
    req_e        req;
    logic        empty;
    logic [31:0] rstart;
    logic [31:0] rend;
    logic [2:0]  rperm;
    logic [31:0] qaddr;
    logic [1:0]  fcode;
  } cmd_t;

endpackage

FILE: design/rtwfc_front.sv
// Front end of the region table: accepts requests, classifies them and queues them.
// Depends on rtwfc_pkg for the request codes and the queued request type.
module rtwfc_front import rtwfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] region_start_i,
  input  logic [31:0] region_end_i,
  input  logic [2:0]  region_perm_i,
  input  logic [31:0] query_addr_i,
  input  logic [1:0]  fault_code_i,
  output logic        cmd_valid_o,
  input  logic        cmd_take_i,
  output cmd_t        cmd_o
);

  // Two-entry queue
  cmd_t       q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       cmd_in;

  assign req_stall_o = (cnt_q == 2'd2);
  assign push        = req_valid_i && !req_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_take_i;
  assign cmd_o       = q_mem[rd_ptr_q];

  // Classify the request: flag an empty range up front
  always_comb begin
    cmd_in.req    = req_e'(req_type_i);
    cmd_in.empty  = (region_start_i >= region_end_i);
    cmd_in.rstart = region_start_i;
    cmd_in.rend   = region_end_i;
    cmd_in.rperm  = region_perm_i;
    cmd_in.qaddr  = query_addr_i;
    cmd_in.fcode  = fault_code_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= cmd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("queue underflow");
  a_cnt_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
`endif

endmodule

FILE: design/rtwfc_back.sv
// Back end of the region table: walks the table one entry a cycle and builds results.
// Depends on rtwfc_pkg for codes, flags and the queued request type.
module rtwfc_back import rtwfc_pkg::*; #(
  parameter int MAX_REGIONS = 16,
  parameter int PAGE_BITS   = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_take_o,
  input  cmd_t        cmd_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [2:0]  status_o,
  output logic        found_o,
  output logic [31:0] hit_start_o,
  output logic [31:0] hit_end_o,
  output logic [2:0]  hit_perm_o,
  output logic        cache_hit_o,
  output logic [31:0] page_addr_o,
  output logic [2:0]  entry_perm_o,
  output logic [4:0]  region_count_o,
  output logic [31:0] fault_total_o
);

  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CACHE, S_SCAN, S_SHIFT, S_RESULT
  } bstate_e;

  // Table memory: one read port, one write port
  logic [31:0] start_mem [MAX_REGIONS];
  logic [31:0] end_mem   [MAX_REGIONS];
  logic [2:0]  perm_mem  [MAX_REGIONS];

  bstate_e     state_q, state_d;
  cmd_t        cmd_q;
  logic [CW-1:0] used_q, used_d;
  logic [IW-1:0] lhi_q, lhi_d;
  logic        lhv_q, lhv_d;
  logic [31:0] fcnt_q, fcnt_d;
  logic [CW-1:0] idx_q, idx_d;       // scan position
  logic [31:0] prev_end_q, prev_end_d;
  logic        chit_q, chit_d;

  // Registered read port
  logic [IW-1:0] raddr;
  logic        rd_en;
  logic [31:0] rs_q, re_q;
  logic [2:0]  rp_q;

  // Write port
  logic        we;
  logic [IW-1:0] waddr;
  logic [31:0] ws, wend;
  logic [2:0]  wp;

  // Output register
  logic        ov_q;
  logic [2:0]  st_q, st_d;
  logic        fd_q, fd_d;
  logic [31:0] hs_q, hs_d, he_q, he_d, pa_q, pa_d;
  logic [2:0]  hp_q, hp_d, ep_q, ep_d;
  logic        load_res;

  // Insert outcome, latched as the scan decides
  logic [2:0]  insert_st_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      start_mem[waddr] <= ws;
      end_mem[waddr]   <= wend;
      perm_mem[waddr]  <= wp;
    end
    if (rd_en) begin
      rs_q <= start_mem[raddr];
      re_q <= end_mem[raddr];
      rp_q <= perm_mem[raddr];
    end
  end

  logic covers;
  assign covers = (rs_q <= cmd_q.qaddr) && (cmd_q.qaddr < re_q);

  // Sequence one request: cache probe, scan, shift, result
  always_comb begin
    logic [2:0] hp;
    logic [2:0] st;
    hp = 3'd0;
    st = ST_OK;
    state_d    = state_q;
    used_d     = used_q;
    lhi_d      = lhi_q;
    lhv_d      = lhv_q;
    fcnt_d     = fcnt_q;
    idx_d      = idx_q;
    prev_end_d = prev_end_q;
    chit_d     = chit_q;
    cmd_take_o = 1'b0;
    rd_en      = 1'b0;
    raddr      = '0;
    we         = 1'b0;
    waddr      = '0;
    ws         = rs_q;
    wend       = re_q;
    wp         = rp_q;
    load_res   = 1'b0;
    st_d = ST_OK; fd_d = 1'b0; hs_d = '0; he_d = '0; hp_d = '0; pa_d = '0; ep_d = '0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          idx_d      = '0;
          prev_end_d = '0;
          chit_d     = 1'b0;
          if (cmd_i.req == REQ_FAULT) fcnt_d = fcnt_q + 32'd1;
          unique case (cmd_i.req)
            REQ_CLEAR: begin
              used_d = '0;
              lhv_d  = 1'b0;
              state_d = S_RESULT;
            end
            REQ_INSERT: begin
              if (cmd_i.empty) begin
                state_d = S_RESULT;
              end else begin
                rd_en = 1'b1;
                state_d = S_SCAN;
              end
            end
            default: begin
              rd_en = 1'b1;
              raddr = lhi_q;
              state_d = S_CACHE;
            end
          endcase
        end
      end
      S_CACHE: begin
        if (lhv_q && ({1'b0, lhi_q} < CW'(used_q)) && covers) begin
          chit_d  = 1'b1;
          state_d = S_RESULT;
        end else begin
          rd_en   = 1'b1;
          raddr   = '0;
          idx_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // rs_q/re_q hold entry idx_q when idx_q < used_q
        if (cmd_q.req == REQ_INSERT) begin
          if (idx_q < used_q && rs_q <= cmd_q.rstart) begin
            prev_end_d = re_q;
            idx_d = idx_q + CW'(1);
            rd_en = 1'b1;
            raddr = IW'(idx_q + CW'(1));
          end else if ((idx_q != '0 && prev_end_q > cmd_q.rstart) ||
                       (idx_q < used_q && cmd_q.rend > rs_q) ||
                       (used_q >= CW'(MAX_REGIONS))) begin
            state_d = S_RESULT;
          end else begin
            // Start shift from the top entry downward
            idx_d = used_q;
            if (used_q != idx_q) begin
              rd_en = 1'b1;
              raddr = IW'(used_q - CW'(1));
            end
            prev_end_d = {{(32-CW){1'b0}}, idx_q};
            state_d = S_SHIFT;
          end
        end else begin
          if (idx_q < used_q && covers) begin
            lhi_d = IW'(idx_q);
            lhv_d = 1'b1;
            state_d = S_RESULT;
          end else if (idx_q + CW'(1) >= used_q) begin
            idx_d = used_q;
            state_d = S_RESULT;
          end else begin
            idx_d = idx_q + CW'(1);
            rd_en = 1'b1;
            raddr = IW'(idx_q + CW'(1));
          end
        end
      end
      S_SHIFT: begin
        // prev_end_q holds the insert position here
        if (idx_q == CW'(prev_end_q)) begin
          we = 1'b1;
          waddr = IW'(idx_q);
          ws = cmd_q.rstart;
          wend = cmd_q.rend;
          wp = cmd_q.rperm;
          used_d = used_q + CW'(1);
          if (lhv_q && {1'b0, lhi_q} >= CW'(idx_q)) lhi_d = lhi_q + IW'(1);
          state_d = S_RESULT;
        end else begin
          we = 1'b1;
          waddr = IW'(idx_q);
          idx_d = idx_q - CW'(1);
          if (idx_q - CW'(1) != CW'(prev_end_q)) begin
            rd_en = 1'b1;
            raddr = IW'(idx_q - CW'(2));
          end
        end
      end
      S_RESULT: begin
        if (!ov_q || !res_stall_i) begin
          load_res = 1'b1;
          state_d  = S_IDLE;
          unique case (cmd_q.req)
            REQ_CLEAR: st_d = ST_OK;
            REQ_INSERT: begin
              if (cmd_q.empty) st_d = ST_EMPTY;
              else st_d = insert_st_q;
            end
            default: begin
              if (chit_q || idx_q < used_q) begin
                fd_d = 1'b1;
                hs_d = rs_q;
                he_d = re_q;
                hp   = rp_q;
                hp_d = hp;
                if (cmd_q.req == REQ_FAULT) begin
                  if (cmd_q.fcode[1]) st = (hp & FLAG_WRITE) != 3'd0 ? ST_OK : ST_NO_WRITE;
                  else if (cmd_q.fcode[0]) st = ST_READ_PRES;
                  else st = (hp & (FLAG_READ | FLAG_EXEC)) != 3'd0 ? ST_OK : ST_NO_READ;
                  st_d = st;
                  if (st == ST_OK) begin
                    ep_d = ENTRY_USER | (((hp & FLAG_WRITE) != 3'd0) ? ENTRY_WRITABLE : 3'd0);
                    pa_d = cmd_q.qaddr & ~((32'd1 << PAGE_BITS) - 32'd1);
                  end
                end
              end else begin
                st_d = ST_NO_REGION;
              end
            end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) insert_st_q <= ST_OK;
    else if (state_q == S_SCAN && cmd_q.req == REQ_INSERT && state_d == S_RESULT)
      insert_st_q <= (used_q >= CW'(MAX_REGIONS) &&
                      !((idx_q != '0 && prev_end_q > cmd_q.rstart) ||
                        (idx_q < used_q && cmd_q.rend > rs_q))) ? ST_FULL : ST_OVERLAP;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) cmd_q <= cmd_i;
    idx_q      <= idx_d;
    prev_end_q <= prev_end_d;
    chit_q     <= chit_d;
    if (load_res) begin
      st_q <= st_d; fd_q <= fd_d; hs_q <= hs_d; he_q <= he_d;
      hp_q <= hp_d; pa_q <= pa_d; ep_q <= ep_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      lhi_q   <= '0;
      lhv_q   <= 1'b0;
      fcnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      lhi_q   <= lhi_d;
      lhv_q   <= lhv_d;
      fcnt_q  <= fcnt_d;
      if (load_res) ov_q <= 1'b1;
      else if (!res_stall_i) ov_q <= 1'b0;
    end
  end

  logic [31:0] ftot_q;
  logic        cht_q;
  logic [4:0]  rc_q;
  always_ff @(posedge clk_i) begin
    if (load_res) begin
      ftot_q <= fcnt_q;
      cht_q  <= chit_q && fd_d;
      rc_q   <= 5'(used_q);
    end
  end

  assign res_valid_o    = ov_q;
  assign status_o       = st_q;
  assign found_o        = fd_q;
  assign hit_start_o    = hs_q;
  assign hit_end_o      = he_q;
  assign hit_perm_o     = hp_q;
  assign cache_hit_o    = cht_q;
  assign page_addr_o    = pa_q;
  assign entry_perm_o   = ep_q;
  assign region_count_o = rc_q;
  assign fault_total_o  = ftot_q;

`ifndef SYNTHESIS
  a_used_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(MAX_REGIONS)) else $error("region count past table size");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && res_stall_i |-> !load_res) else $error("result overwritten while stalled");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o |-> state_q == S_IDLE) else $error("request taken while busy");
  a_write_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> state_q == S_SHIFT) else $error("table written outside shift");
`endif

endmodule

FILE: design/region_table_with_fault_check.sv
// Top level of the region table with fault check.
// Depends on rtwfc_pkg, rtwfc_front and rtwfc_back.
//
//   channel | direction | handshake                    | payload
//   req     | in        | req_valid_i / req_stall_o    | req_type .. fault_code
//   res     | out       | res_valid_o / res_stall_i    | status .. fault_total
//
// A clear or an empty insert goes straight to its result, a cache hit to its
// result after the cache probe; a lookup or fault that misses the cache, or an
// insert, walks the table through the single registered read port of the
// region memory, an insert scanning and, if it fits, shifting entries. Lookups
// scan one entry a cycle. The front queue holds two requests, taken while the
// back walks the table or the result waits. Reset is asynchronous and clears
// counts and the cache; table contents are written before read.
module region_table_with_fault_check import rtwfc_pkg::*; #(
  parameter int MAX_REGIONS = 16,
  parameter int PAGE_BITS   = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] region_start_i,
  input  logic [31:0] region_end_i,
  input  logic [2:0]  region_perm_i,
  input  logic [31:0] query_addr_i,
  input  logic [1:0]  fault_code_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [2:0]  status_o,
  output logic        found_o,
  output logic [31:0] hit_start_o,
  output logic [31:0] hit_end_o,
  output logic [2:0]  hit_perm_o,
  output logic        cache_hit_o,
  output logic [31:0] page_addr_o,
  output logic [2:0]  entry_perm_o,
  output logic [4:0]  region_count_o,
  output logic [31:0] fault_total_o
);

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  rtwfc_front u_front (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_type_i, .region_start_i,
    .region_end_i, .region_perm_i, .query_addr_i, .fault_code_i,
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  rtwfc_back #(.MAX_REGIONS(MAX_REGIONS), .PAGE_BITS(PAGE_BITS)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .res_valid_o, .res_stall_i, .status_o, .found_o, .hit_start_o, .hit_end_o,
    .hit_perm_o, .cache_hit_o, .page_addr_o, .entry_perm_o, .region_count_o,
    .fault_total_o
  );

endmodule

FILE: tb/region_table_checker.sv
// Checker for the region table with fault check: watches both channels,
// predicts each result from its own table model and compares. Uses rtwfc_pkg.
module region_table_checker import rtwfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_stall_i,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] region_start_i,
  input  logic [31:0] region_end_i,
  input  logic [2:0]  region_perm_i,
  input  logic [31:0] query_addr_i,
  input  logic [1:0]  fault_code_i,
  input  logic        res_valid_i,
  input  logic        res_stall_i,
  input  logic [2:0]  status_i,
  input  logic        found_i,
  input  logic [31:0] hit_start_i,
  input  logic [31:0] hit_end_i,
  input  logic [2:0]  hit_perm_i,
  input  logic        cache_hit_i,
  input  logic [31:0] page_addr_i,
  input  logic [2:0]  entry_perm_i,
  input  logic [4:0]  region_count_i,
  input  logic [31:0] fault_total_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int NREG = 16;
  localparam int PBITS = 12;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [31:0] hstart;
    logic [31:0] hend;
    logic [2:0]  hperm;
    logic        chit;
    logic [31:0] paddr;
    logic [2:0]  eperm;
    logic [4:0]  count;
    logic [31:0] ftotal;
  } region_result_t;

  logic [31:0] tbl_start [NREG+1];
  logic [31:0] tbl_end   [NREG+1];
  logic [2:0]  tbl_perm  [NREG+1];
  int          tbl_used;
  int          last_idx;
  logic        last_ok;
  logic [31:0] faults_seen;
  region_result_t expected_results[$];

  // Walk the table: cached entry first, then in order
  function automatic int find_cover(logic [31:0] a, output logic hit);
    hit = 1'b0;
    if (last_ok && last_idx < tbl_used && tbl_start[last_idx] <= a && a < tbl_end[last_idx]) begin
      hit = 1'b1;
      return last_idx;
    end
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_start[i] <= a && a < tbl_end[i]) begin
        last_idx = i;
        last_ok = 1'b1;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic status_e insert_entry(logic [31:0] s, logic [31:0] e, logic [2:0] p);
    int pos;
    pos = 0;
    if (s >= e) return ST_EMPTY;
    while (pos < tbl_used && tbl_start[pos] <= s) pos++;
    if (pos > 0 && tbl_end[pos-1] > s) return ST_OVERLAP;
    if (pos < tbl_used && e > tbl_start[pos]) return ST_OVERLAP;
    if (tbl_used >= NREG) return ST_FULL;
    for (int i = tbl_used; i > pos; i--) begin
      tbl_start[i] = tbl_start[i-1];
      tbl_end[i] = tbl_end[i-1];
      tbl_perm[i] = tbl_perm[i-1];
    end
    tbl_start[pos] = s;
    tbl_end[pos] = e;
    tbl_perm[pos] = p;
    tbl_used++;
    if (last_ok && last_idx >= pos) last_idx++;
    return ST_OK;
  endfunction

  function automatic region_result_t predict_result(req_e rq, logic [31:0] s, logic [31:0] e,
                                                    logic [2:0] p, logic [31:0] a,
                                                    logic [1:0] fc);
    region_result_t r;
    int k;
    logic hit;
    r = '0;
    r.status = ST_OK;
    if (rq == REQ_INSERT) begin
      r.status = insert_entry(s, e, p);
    end else if (rq == REQ_CLEAR) begin
      tbl_used = 0;
      last_ok = 1'b0;
    end else begin
      k = find_cover(a, hit);
      if (rq == REQ_FAULT) faults_seen++;
      if (k < 0) begin
        r.status = ST_NO_REGION;
      end else begin
        r.found = 1'b1;
        r.chit = hit;
        r.hstart = tbl_start[k];
        r.hend = tbl_end[k];
        r.hperm = tbl_perm[k];
        if (rq == REQ_FAULT) begin
          if (fc[1]) r.status = (r.hperm & FLAG_WRITE) ? ST_OK : ST_NO_WRITE;
          else if (fc[0]) r.status = ST_READ_PRES;
          else r.status = (r.hperm & (FLAG_READ | FLAG_EXEC)) ? ST_OK : ST_NO_READ;
          if (r.status == ST_OK) begin
            r.eperm = ENTRY_USER | ((r.hperm & FLAG_WRITE) ? ENTRY_WRITABLE : 3'd0);
            r.paddr = a & ~((32'd1 << PBITS) - 32'd1);
          end
        end
      end
    end
    r.count = tbl_used[4:0];
    r.ftotal = faults_seen;
    return r;
  endfunction

  assign pending_o = expected_results.size();

  // Predict on accepted requests, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    region_result_t want;
    if (!rst_ni) begin
      tbl_used <= 0;
      last_idx <= 0;
      last_ok <= 1'b0;
      faults_seen <= '0;
      fail_count_o <= 0;
    end else begin
      if (res_valid_i && !res_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result, status %0d", status_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_results.pop_front();
          if ({status_i, found_i, hit_start_i, hit_end_i, hit_perm_i, cache_hit_i,
               page_addr_i, entry_perm_i, region_count_i, fault_total_i} !== want) begin
            fail_count_o <= fail_count_o + 1;
            if (status_i !== want.status)
              $error("status expected %0d actual %0d", want.status, status_i);
            if (found_i !== want.found)
              $error("found expected %0d actual %0d", want.found, found_i);
            if (hit_start_i !== want.hstart)
              $error("hit_start expected %h actual %h", want.hstart, hit_start_i);
            if (hit_end_i !== want.hend)
              $error("hit_end expected %h actual %h", want.hend, hit_end_i);
            if (hit_perm_i !== want.hperm)
              $error("hit_perm expected %0d actual %0d", want.hperm, hit_perm_i);
            if (cache_hit_i !== want.chit)
              $error("cache_hit expected %0d actual %0d", want.chit, cache_hit_i);
            if (page_addr_i !== want.paddr)
              $error("page_addr expected %h actual %h", want.paddr, page_addr_i);
            if (entry_perm_i !== want.eperm)
              $error("entry_perm expected %0d actual %0d", want.eperm, entry_perm_i);
            if (region_count_i !== want.count)
              $error("region_count expected %0d actual %0d", want.count, region_count_i);
            if (fault_total_i !== want.ftotal)
              $error("fault_total expected %0d actual %0d", want.ftotal, fault_total_i);
          end
        end
      end
      if (req_valid_i && !req_stall_i)
        expected_results.push_back(predict_result(req_e'(req_type_i), region_start_i,
                                                  region_end_i, region_perm_i,
                                                  query_addr_i, fault_code_i));
    end
  end

endmodule

FILE: tb/tb_region_table_with_fault_check.sv
// Testbench top for the region table with fault check: drives requests and
// result stalls, gives the verdict. Uses rtwfc_pkg and region_table_checker.
module tb_region_table_with_fault_check;
  import rtwfc_pkg::*;

  localparam int NUM_RANDOM = 1430;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i, rst_ni;
  logic        req_valid_i, req_stall_o;
  logic [1:0]  req_type_i;
  logic [31:0] region_start_i, region_end_i, query_addr_i;
  logic [2:0]  region_perm_i;
  logic [1:0]  fault_code_i;
  logic        res_valid_o, res_stall_i;
  logic [2:0]  status_o, hit_perm_o, entry_perm_o;
  logic        found_o, cache_hit_o;
  logic [31:0] hit_start_o, hit_end_o, page_addr_o, fault_total_o;
  logic [4:0]  region_count_o;
  int          fail_count, pending, cycle_count;
  logic        hold_off;

  region_table_with_fault_check u_dut (.*);

  region_table_checker u_chk (
    .req_stall_i(req_stall_o), .res_valid_i(res_valid_o),
    .status_i(status_o), .found_i(found_o), .hit_start_i(hit_start_o),
    .hit_end_i(hit_end_o), .hit_perm_i(hit_perm_o), .cache_hit_i(cache_hit_o),
    .page_addr_i(page_addr_o), .entry_perm_i(entry_perm_o),
    .region_count_i(region_count_o), .fault_total_i(fault_total_o),
    .fail_count_o(fail_count), .pending_o(pending), .*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stall results on a pattern of their own, with one long hold-off
  initial begin
    res_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) res_stall_i <= 1'b1;
      else if (cycle_count[9:8] == 2'd0) res_stall_i <= 1'b0;
      else res_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    hold_off = 1'b0;
    @(posedge rst_ni);
    repeat (600) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Offer one request and hold it until accepted
  task automatic send_request(req_e rq, logic [31:0] s, logic [31:0] e, logic [2:0] p,
                              logic [31:0] a, logic [1:0] fc);
    req_valid_i <= 1'b1;
    req_type_i <= rq;
    region_start_i <= s;
    region_end_i <= e;
    region_perm_i <= p;
    query_addr_i <= a;
    fault_code_i <= fc;
    do @(posedge clk_i); while (req_stall_o);
  endtask

  // Drop valid for a gap of length n; a zero gap leaves valid alone
  task automatic pause_sender(int n);
    if (n > 0) begin
      req_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Pick an address near the small working window, in the top page, or anywhere
  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'hFFFF_F000 | $urandom_range(0, 32'hFFF);
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  initial begin
    logic [31:0] s, e;
    int burst;
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    req_type_i = REQ_INSERT;
    region_start_i = '0;
    region_end_i = '0;
    region_perm_i = '0;
    query_addr_i = '0;
    fault_code_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, empty ranges, extremes, overlaps, equal starts
    send_request(REQ_LOOKUP, '0, '0, '0, 32'h0, 2'd0);
    send_request(REQ_FAULT, '0, '0, '0, 32'hFFFF_FFFF, 2'd3);
    send_request(REQ_INSERT, 32'h10, 32'h10, 3'd7, '0, '0);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h0, 3'd7, '0, '0);
    send_request(REQ_INSERT, 32'h0, 32'h1000, 3'd1, '0, '0);
    send_request(REQ_INSERT, 32'hFFFF_F000, 32'hFFFF_FFFF, 3'd2, '0, '0);
    send_request(REQ_INSERT, 32'h0, 32'h10, 3'd7, '0, '0);
    send_request(REQ_INSERT, 32'h800, 32'h2000, 3'd7, '0, '0);
    send_request(REQ_INSERT, 32'h3000, 32'h5000, 3'd4, '0, '0);
    send_request(REQ_INSERT, 32'h2000, 32'h3001, 3'd0, '0, '0);
    send_request(REQ_INSERT, 32'h2000, 32'h3000, 3'd0, '0, '0);
    send_request(REQ_LOOKUP, '0, '0, '0, 32'h3FFF, 2'd0);
    send_request(REQ_LOOKUP, '0, '0, '0, 32'h3000, 2'd0);
    send_request(REQ_INSERT, 32'h1000, 32'h2000, 3'd3, '0, '0);
    send_request(REQ_FAULT, '0, '0, '0, 32'h3ABC, 2'd0);
    send_request(REQ_FAULT, '0, '0, '0, 32'h2ABC, 2'd0);
    send_request(REQ_FAULT, '0, '0, '0, 32'h0FFF, 2'd1);
    send_request(REQ_FAULT, '0, '0, '0, 32'h0123, 2'd2);
    send_request(REQ_FAULT, '0, '0, '0, 32'hFFFF_FFFE, 2'd2);
    send_request(REQ_FAULT, '0, '0, '0, 32'h1FFF, 2'd3);
    send_request(REQ_FAULT, '0, '0, '0, 32'hFFFF_FFFF, 2'd2);
    for (int i = 0; i < 13; i++)
      send_request(REQ_INSERT, 32'h10000 + i * 32'h100, 32'h10000 + i * 32'h100 + 32'h80,
                   3'(i), '0, '0);
    send_request(REQ_CLEAR, '0, '0, '0, '0, '0);

    // Random: mostly inserts and queries in a small window, some clears
    burst = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        pause_sender($urandom_range(0, 12) == 0 ? $urandom_range(1, 40) : $urandom_range(0, 3));
      end
      burst--;
      case ($urandom_range(0, 19))
        0: send_request(REQ_CLEAR, $urandom(), $urandom(), 3'($urandom()), $urandom(),
                        2'($urandom()));
        1, 2, 3, 4, 5, 6: begin
          s = pick_addr();
          e = ($urandom_range(0, 9) == 0) ? $urandom() : s + $urandom_range(0, 32'h3000);
          send_request(REQ_INSERT, s, e, 3'($urandom()), $urandom(), 2'($urandom()));
        end
        7, 8, 9, 10, 11: send_request(REQ_LOOKUP, $urandom(), $urandom(), 3'($urandom()),
                                      pick_addr(), 2'($urandom()));
        default: send_request(REQ_FAULT, $urandom(), $urandom(), 3'($urandom()),
                              pick_addr(), 2'($urandom()));
      endcase
    end
    req_valid_i <= 1'b0;

    // Drain, then allow the block's latency
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
